// ----- src/ptw_pkg.sv -----
// shared types, codes and constants for the four-level page table walker
package ptw_pkg;

  localparam int ADDR_W          = 48;
  localparam int DATA_W          = 64;
  localparam int WIDX_W          = 12;
  localparam int IDX_W           = 9;
  localparam int PAGE_OFS_W      = 12;
  localparam int TABLE_WORDS_DEF = 4096;

  localparam logic [ADDR_W-1:0] FRAME_MASK = 48'hFFFF_FFFF_F000;

  // item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROOT   = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ROOT_ZERO = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_OUTSIDE   = 2'd3;

  localparam logic [1:0] LEVEL_LAST = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_addr;
    logic [1:0]        status;
    logic [1:0]        fault_level;
  } res_t;

  // 9-bit table index of a virtual address at a given level
  function automatic logic [IDX_W-1:0] level_index(input logic [ADDR_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ----- src/ptw_tmem.sv -----
// descriptor table memory: one write port, one read port with registered data
module ptw_tmem #(
  parameter int TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ptw_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ptw_pkg::DATA_W-1:0] rd_data
);
  import ptw_pkg::*;

  logic [DATA_W-1:0] mem [TABLE_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/ptw_walk.sv -----
// walk sequencer: takes items, issues table reads level by level, builds the result
module ptw_walk #(
  parameter int TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [ptw_pkg::ADDR_W-1:0]  virt_addr,
  input  logic [ptw_pkg::WIDX_W-1:0]  word_index,
  input  logic [ptw_pkg::DATA_W-1:0]  word_data,
  input  logic [ptw_pkg::ADDR_W-1:0]  root_table_addr,
  input  logic [ptw_pkg::ADDR_W-1:0]  window_base_addr,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [ptw_pkg::DATA_W-1:0]  mem_wr_data,
  output logic                        mem_rd_en,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [ptw_pkg::DATA_W-1:0]  mem_rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ptw_pkg::res_t               res
);
  import ptw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [ADDR_W-4:0] WIN_WORDS = (ADDR_W-3)'(TABLE_WORDS);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [ADDR_W-1:0] va;
  logic [1:0]        lvl;
  logic [ADDR_W-1:0] rel;     // table base minus window base, mod 2^48
  res_t              res_q;

  logic              accept;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] ofs;
  logic              in_window;
  logic [ADDR_W-1:0] frame;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign idx       = level_index(va, lvl);
  assign ofs       = rel + {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
  assign in_window = ofs[ADDR_W-1:3] < WIN_WORDS;
  assign frame     = mem_rd_data[ADDR_W-1:0] & FRAME_MASK;

  // writes only happen in idle, reads only mid walk: no overlap on one entry
  assign mem_wr_en   = accept && (func == FUNC_WRITE) &&
                       (32'(word_index) < 32'(TABLE_WORDS));
  assign mem_wr_addr = AW'(word_index);
  assign mem_wr_data = word_data;
  assign mem_rd_en   = (state == S_ADDR) && in_window;
  assign mem_rd_addr = ofs[AW+2:3];

  assign res_valid = (state == S_FIN);
  assign res       = res_q;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_WRITE || root_table_addr == '0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        state_next = in_window ? S_DATA : S_FIN;
      end
      S_DATA: begin
        if (!mem_rd_data[0] || lvl == LEVEL_LAST) begin
          state_next = S_FIN;
        end else begin
          state_next = S_ADDR;
        end
      end
      default: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          va    <= virt_addr;
          lvl   <= 2'd0;
          rel   <= root_table_addr - window_base_addr;
          res_q <= '{phys_addr: '0,
                     status: (func == FUNC_XLATE && root_table_addr == '0) ?
                             ST_ROOT_ZERO : ST_OK,
                     fault_level: 2'd0};
        end
      end
      S_ADDR: begin
        if (!in_window) begin
          res_q <= '{phys_addr: '0, status: ST_OUTSIDE, fault_level: lvl};
        end
      end
      S_DATA: begin
        if (!mem_rd_data[0]) begin
          res_q <= '{phys_addr: '0, status: ST_INVALID, fault_level: lvl};
        end else if (lvl == LEVEL_LAST) begin
          res_q <= '{phys_addr: frame | {{(ADDR_W-PAGE_OFS_W){1'b0}},
                                         va[PAGE_OFS_W-1:0]},
                     status: ST_OK, fault_level: 2'd0};
        end else begin
          rel <= frame - window_base_addr;
          lvl <= lvl + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/four_level_page_table_walker_top.sv -----
// four-level page table walker: config registers, walk sequencer, table memory, result register
// walk: a translate item gets an address check and a registered memory read per level, then
//   a finish state, before the result register; a write or zero root goes straight to finish
// flow: one item at a time, paced by the four dependent table memory reads; a new item is
//   taken once the last leaves finish for the result register; a fault ends a walk early
// reset: control state and configuration registers clear; table memory is not cleared
module four_level_page_table_walker_top #(
  parameter int TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [ptw_pkg::ADDR_W-1:0]  cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [ptw_pkg::ADDR_W-1:0]  virt_addr,
  input  logic [ptw_pkg::WIDX_W-1:0]  word_index,
  input  logic [ptw_pkg::DATA_W-1:0]  word_data,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ptw_pkg::ADDR_W-1:0]  phys_addr,
  output logic [1:0]                  status,
  output logic [1:0]                  fault_level
);
  import ptw_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);

  // configuration registers
  logic [ADDR_W-1:0] root_table_addr;
  logic [ADDR_W-1:0] window_base_addr;

  // sequencer to memory
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;

  // sequencer to result register
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              res_load;

  // user must keep config writes to idle; the block does not enforce it, avoiding walk hazards
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_addr  <= '0;
      window_base_addr <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROOT:   root_table_addr  <= cfg_data;
        CFG_WINDOW: window_base_addr <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ptw_walk #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_walk (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .virt_addr        (virt_addr),
    .word_index       (word_index),
    .word_data        (word_data),
    .root_table_addr  (root_table_addr),
    .window_base_addr (window_base_addr),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_en        (mem_rd_en),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  ptw_tmem #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_tmem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // result register: the sequencer hands over when the slot is empty or draining,
  // so the next item can be taken while this one waits downstream
  assign res_ready = !out_valid || out_ready;
  assign res_load  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_load) begin
      phys_addr   <= res.phys_addr;
      status      <= res.status;
      fault_level <= res.fault_level;
    end
  end

endmodule

// ----- sim/tb_four_level_page_table_walker_top.sv -----
// self-checking testbench for the four-level page table walker
`timescale 1ns / 100ps

module tb_four_level_page_table_walker_top;
  import ptw_pkg::*;

  localparam int TABLE_WORDS = TABLE_WORDS_DEF;
  // table memory spans this many bytes of physical address space
  localparam logic [ADDR_W-1:0] WINDOW_BYTES = 48'(8 * TABLE_WORDS);

  // one input item as the sender holds it
  typedef struct {
    logic              fn;
    logic [ADDR_W-1:0] va;
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] wdata;
  } walker_item_t;

  // what the stimulus plants in a fresh descriptor word
  typedef enum {DESC_LINK, DESC_HOLE, DESC_AWAY} desc_kind_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // block ports, inputs at known values from time zero
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = CFG_ROOT;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_WRITE;
  logic [ADDR_W-1:0] virt_addr = '0;
  logic [WIDX_W-1:0] word_index = '0;
  logic [DATA_W-1:0] word_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] phys_addr;
  logic [1:0]        status;
  logic [1:0]        fault_level;

  four_level_page_table_walker_top #(
    .TABLE_WORDS(TABLE_WORDS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .virt_addr  (virt_addr),
    .word_index (word_index),
    .word_data  (word_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .phys_addr  (phys_addr),
    .status     (status),
    .fault_level(fault_level)
  );

  // register values as last written (the block sees them from the next edge on)
  logic [ADDR_W-1:0] cur_root = '0;
  logic [ADDR_W-1:0] cur_window = '0;

  // two views of table memory: the planned one runs ahead while items are queued,
  // the stored one follows the items the block has actually taken
  logic [DATA_W-1:0] plan_words   [TABLE_WORDS];
  bit                plan_written [TABLE_WORDS];
  logic [DATA_W-1:0] stored_words [TABLE_WORDS];

  walker_item_t queued_requests[$];
  res_t         awaited_outcomes[$];
  walker_item_t on_wire;
  res_t         want;

  int planned_items = 0;
  int fail_count = 0;
  int n_writes = 0;
  int n_xlates = 0;
  int n_settings = 1;
  int outcome_count[4] = '{0, 0, 0, 0};

  // walk the four levels for va; on the planned view a read of a word that was
  // never written stops the walk and reports the word and level instead
  function automatic void walk_tables(input bit on_plan, input logic [ADDR_W-1:0] va,
                                      output res_t res, output int miss_word,
                                      output int miss_lvl);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] ofs;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] desc;
    int                word;
    res = '0;
    miss_word = -1;
    miss_lvl = -1;
    base = cur_root;
    if (base == '0) begin
      res.status = ST_ROOT_ZERO;
      return;
    end
    for (int lvl = 0; lvl < 4; lvl++) begin
      idx = IDX_W'(va >> (39 - 9 * lvl));
      addr = base + (ADDR_W'(idx) << 3);
      // offset into the window wraps at 48 bits like the address itself
      ofs = addr - cur_window;
      if (ofs >= WINDOW_BYTES) begin
        res.status = ST_OUTSIDE;
        res.fault_level = 2'(lvl);
        return;
      end
      // low three offset bits only matter for an unaligned root or window and are dropped
      word = int'(ofs >> 3);
      if (on_plan && !plan_written[word]) begin
        miss_word = word;
        miss_lvl = lvl;
        return;
      end
      desc = on_plan ? plan_words[word] : stored_words[word];
      if (!desc[0]) begin
        res.status = ST_INVALID;
        res.fault_level = 2'(lvl);
        return;
      end
      base = desc[ADDR_W-1:0] & FRAME_MASK;
    end
    res.phys_addr = base | ADDR_W'(va[PAGE_OFS_W-1:0]);
  endfunction

  // item accepted by the block: update the stored view and owe its result
  task automatic take_request(input walker_item_t it);
    res_t r;
    int   mw;
    int   ml;
    r = '0;
    if (it.fn == FUNC_WRITE) begin
      if (it.widx < TABLE_WORDS)
        stored_words[it.widx] = it.wdata;
      n_writes++;
    end else begin
      walk_tables(1'b0, it.va, r, mw, ml);
      n_xlates++;
      outcome_count[r.status]++;
    end
    awaited_outcomes.push_back(r);
  endtask

  // build a descriptor; random bits fill everything the walker does not look at
  function automatic logic [DATA_W-1:0] make_desc(input int lvl, input desc_kind_t kind,
                                                   input bit pick_random);
    logic [DATA_W-1:0] d;
    logic [ADDR_W-1:0] frame;
    int                k;
    d = {$urandom, $urandom};
    case (kind)
      DESC_HOLE: begin
        d[0] = 1'b0;
      end
      DESC_AWAY: begin
        // next table sits past the end of the window for any index
        frame = ((cur_window + 48'h8FFF) & FRAME_MASK)
                + (48'($urandom_range(0, 65535)) << 12);
        d[ADDR_W-1:12] = frame[ADDR_W-1:12];
        d[0] = 1'b1;
      end
      default: begin
        // one of the 4k tables inside the window; a leaf keeps its random frame
        if (lvl < 3) begin
          k = pick_random ? $urandom_range(0, 6) : lvl + 2;
          frame = (cur_window + (48'(k) << 12) + 48'hFFF) & FRAME_MASK;
          d[ADDR_W-1:12] = frame[ADDR_W-1:12];
        end
        d[0] = 1'b1;
      end
    endcase
    return d;
  endfunction

  task automatic plan_write(input logic [WIDX_W-1:0] widx, input logic [DATA_W-1:0] wdata);
    walker_item_t it;
    it.fn = FUNC_WRITE;
    it.va = {$urandom, $urandom};
    it.widx = widx;
    it.wdata = wdata;
    if (widx < TABLE_WORDS) begin
      plan_words[widx] = wdata;
      plan_written[widx] = 1'b1;
    end
    queued_requests.push_back(it);
    planned_items++;
  endtask

  // translate va, first writing every table word the walk would read unwritten;
  // directed walks plant fault_kind at fault_lvl and links elsewhere
  task automatic plan_translate(input logic [ADDR_W-1:0] va, input bit pick_random,
                                input int fault_lvl, input desc_kind_t fault_kind);
    res_t         r;
    int           mw;
    int           ml;
    int           roll;
    desc_kind_t   kind;
    walker_item_t it;
    walk_tables(1'b1, va, r, mw, ml);
    while (mw >= 0) begin
      if (pick_random) begin
        roll = $urandom_range(0, 99);
        if (roll < 10)
          kind = DESC_HOLE;
        else if (roll < 18 && ml < 3)
          kind = DESC_AWAY;
        else
          kind = DESC_LINK;
      end else begin
        kind = (ml == fault_lvl) ? fault_kind : DESC_LINK;
      end
      plan_write(WIDX_W'(mw), make_desc(ml, kind, pick_random));
      walk_tables(1'b1, va, r, mw, ml);
    end
    it.fn = FUNC_XLATE;
    it.va = va;
    it.widx = WIDX_W'($urandom);
    it.wdata = {$urandom, $urandom};
    queued_requests.push_back(it);
    planned_items++;
  endtask

  // random mix: mostly walks over a few hot indices, some wild addresses and stray writes
  task automatic plan_random(input int count);
    logic [ADDR_W-1:0] va;
    int                target;
    target = planned_items + count;
    while (planned_items < target) begin
      if ($urandom_range(0, 3) == 0) begin
        plan_write(WIDX_W'($urandom), {$urandom, $urandom});
      end else begin
        for (int lvl = 0; lvl < 4; lvl++)
          va[47 - 9 * lvl -: 9] = ($urandom_range(0, 3) != 0) ? 9'($urandom_range(0, 3))
                                                               : 9'($urandom);
        va[PAGE_OFS_W-1:0] = PAGE_OFS_W'($urandom);
        plan_translate(va, 1'b1, -1, DESC_LINK);
      end
    end
  endtask

  task automatic set_register(input logic idx, input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_ROOT)
      cur_root = value;
    else
      cur_window = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every queued item is taken and every result is back, then let the
  // walker settle for longer than one full translation takes
  task automatic await_drain();
    while (queued_requests.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] window, input logic [ADDR_W-1:0] root,
                           input int count);
    await_drain();
    set_register(CFG_WINDOW, window);
    set_register(CFG_ROOT, root);
    n_settings++;
    plan_random(count);
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      // the item on the wire, if any, was taken at this edge
      if (in_valid)
        take_request(on_wire);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_requests.size() != 0) begin
        on_wire = queued_requests.pop_front();
        in_valid <= 1'b1;
        func <= on_wire.fn;
        virt_addr <= on_wire.va;
        word_index <= on_wire.widx;
        word_data <= on_wire.wdata;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: ready follows the bits of a 32-bit random pattern in turn, redrawn each time it runs out
  logic [31:0] stall_bits = '1;
  int          stall_step = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_step = 0;
    end else begin
      if (stall_step == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_bits = '1;
          1:       stall_bits = $urandom & $urandom;
          default: stall_bits = $urandom;
        endcase
      end
      out_ready <= stall_bits[stall_step];
      stall_step = (stall_step + 1) % 32;
    end
  end

  // result checker: each result item against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result item with nothing owed: phys_addr %h status %0d fault_level %0d",
               phys_addr, status, fault_level);
        fail_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (phys_addr !== want.phys_addr) begin
          $error("phys_addr: expected %h, got %h", want.phys_addr, phys_addr);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (fault_level !== want.fault_level) begin
          $error("fault_level: expected %0d, got %0d", want.fault_level, fault_level);
          fail_count++;
        end
      end
    end
  end

  // stimulus and run control
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: no root, so every walk ends at once
    plan_write(12'hFFF, '1);
    plan_write(12'h000, '0);
    plan_translate('0, 1'b0, 4, DESC_LINK);
    plan_translate('1, 1'b0, 4, DESC_LINK);
    plan_random(20);

    // window at zero, root on the second table: full walks, then a hole at every
    // level and a link out of the window below each of the first three levels
    await_drain();
    set_register(CFG_WINDOW, '0);
    set_register(CFG_ROOT, 48'h1000);
    n_settings++;
    plan_translate('0, 1'b0, 4, DESC_LINK);
    plan_translate('1, 1'b0, 4, DESC_LINK);
    for (int lvl = 0; lvl < 4; lvl++) begin
      plan_translate(48'(1) << (39 - 9 * lvl), 1'b0, lvl, DESC_HOLE);
      if (lvl < 3)
        plan_translate(48'(2) << (39 - 9 * lvl), 1'b0, lvl, DESC_AWAY);
    end
    plan_random(70);

    // window just under the top of the address space: table addresses wrap to zero
    run_phase(48'hFFFF_FFFF_C000, 48'hFFFF_FFFF_F000, 90);

    // both registers at their maximum: unaligned window and root, wrapping offsets
    run_phase('1, '1, 80);

    // a random aligned window with an unaligned root inside it
    run_phase({$urandom, $urandom} & FRAME_MASK, '0, 0);
    run_phase(cur_window, cur_window + 48'h2000 + 48'($urandom_range(1, 7)), 80);

    // root right past the end of the window: every walk leaves at the first level
    run_phase(cur_window, cur_window + WINDOW_BYTES, 20);

    await_drain();
    $display("covered %0d table writes and %0d translations over %0d register settings",
             n_writes, n_xlates, n_settings);
    $display("walk outcomes: ok %0d, no root %0d, invalid entry %0d, out of window %0d",
             outcome_count[ST_OK], outcome_count[ST_ROOT_ZERO], outcome_count[ST_INVALID],
             outcome_count[ST_OUTSIDE]);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("timeout with %0d items queued and %0d results owed",
             queued_requests.size(), awaited_outcomes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
